[hw/rtl/lcs_pkg.sv]
// ----------------------------------------------------------------------------
// LBP code stream package
// Widths, register indexes, queue record and the neighbour comparison function.
// ----------------------------------------------------------------------------
package lcs_pkg;

   localparam int PIX_W         = 8;
   localparam int CODE_W        = 8;
   localparam int ROW_W         = 12;
   localparam int OUT_COL_W     = 10;
   localparam int CFG_WIDTH_W   = 11;
   localparam int CFG_HEIGHT_W  = 13;
   localparam int MAX_HEIGHT    = 4096;
   localparam int DEF_MAX_WIDTH = 1024;
   localparam int RESET_WIDTH   = 128;
   localparam int RESET_HEIGHT  = 128;

   localparam int QUEUE_DEPTH = 4;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

   // Emission slots of one pixel, in output order.
   localparam int EMIT_PREV_ROW_LEFT = 0;  // (r-1, c-1)
   localparam int EMIT_PREV_ROW_END  = 1;  // (r-1, c) at row end
   localparam int EMIT_LAST_ROW_LEFT = 2;  // (r, c-1) on last row
   localparam int EMIT_LAST_ROW_END  = 3;  // (r, c) on last row, frame end
   localparam int EMIT_N             = 4;

   // Neighbour order: up, up-right, right, down-right, down, down-left, left, up-left.
   localparam int DR [8] = '{-1, -1, 0, 1, 1, 1, 0, -1};
   localparam int DC [8] = '{ 0,  1, 1, 1, 0, -1, -1, -1};

   // Window cells: index row*3+col, col 2 newest, row 2 current row.
   typedef logic [8:0][PIX_W-1:0] lcs_win_type;

   typedef struct packed {
      logic up;
      logic down;
      logic left;
      logic right;
   } lcs_side_type;

   typedef struct packed {
      lcs_win_type      win;
      logic [ROW_W-1:0] row;
      logic             last_col;
      logic             last_row;
   } lcs_item_type;

   function automatic logic [CODE_W-1:0] lcs_code(lcs_win_type win, logic [1:0] cr,
                                                  logic [1:0] cc, lcs_side_type side);
      logic [CODE_W-1:0] code;
      int                r;
      int                c;
      logic              skip;
      code = '0;
      for (int i = 0; i < 8; i++) begin
         r    = int'(cr) + DR[i];
         c    = int'(cc) + DC[i];
         skip = (DR[i] < 0 && !side.up) || (DR[i] > 0 && !side.down) ||
                (DC[i] < 0 && !side.left) || (DC[i] > 0 && !side.right) ||
                r < 0 || r > 2 || c < 0 || c > 2;
         if (!skip) begin
            if (win[int'(cr) * 3 + int'(cc)] <= win[r * 3 + c]) begin
               code[7 - i] = 1'b1;
            end
         end
      end
      return code;
   endfunction

endpackage

[hw/rtl/lcs_ram.sv]
// ----------------------------------------------------------------------------
// LBP generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lcs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/lcs_front.sv]
// ----------------------------------------------------------------------------
// LBP front end
// Accepts pixels, tracks the raster position, keeps the line stores and the
// 3x3 window, and pushes one record per pixel into the queue.
// ----------------------------------------------------------------------------
module lcs_front #(
   parameter int MAX_WIDTH = lcs_pkg::DEF_MAX_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [lcs_pkg::PIX_W-1:0]      req_pixel,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [lcs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lcs_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic [lcs_pkg::CNT_W-1:0]      q_count,
   output logic                           push_valid,
   output lcs_pkg::lcs_item_type          push_item,
   output logic [$clog2(MAX_WIDTH)-1:0]   push_col
);

   import lcs_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int CW1   = COL_W + 1;
   localparam int EW    = $clog2(MAX_WIDTH + 1);
   localparam int RST_W = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
   localparam int LW    = 2 * PIX_W;

   logic [EW-1:0]           width_ff, width_in;
   logic [CFG_HEIGHT_W-1:0] height_ff, height_in;
   logic [COL_W-1:0]        col_ff, col_in;
   logic [ROW_W-1:0]        row_ff, row_in;

   logic                    s1_v_ff;
   logic [PIX_W-1:0]        s1_px_ff;
   logic [COL_W-1:0]        s1_col_ff;
   logic [ROW_W-1:0]        s1_row_ff;
   logic                    s1_lc_ff;
   logic                    s1_lr_ff;

   logic                    byp_v_ff;
   logic [LW-1:0]           byp_data_ff;
   lcs_win_type             win_ff, win_in;

   logic                    accept;
   logic                    cfg_hit;
   logic                    last_col;
   logic                    last_row;
   logic [LW-1:0]           ram_rdata;
   logic [LW-1:0]           line_word;
   logic [LW-1:0]           wr_word;
   logic [PIX_W-1:0]        top_px;
   logic [PIX_W-1:0]        mid_px;
   int                      wv;
   int                      hv;

   assign csr_ready = 1'b1;
   assign req_ready = ((CNT_W + 1)'(q_count) + (CNT_W + 1)'(s1_v_ff)) <
                      (CNT_W + 1)'(QUEUE_DEPTH);
   assign accept    = req_valid && req_ready;
   assign cfg_hit   = csr_valid && (csr_index == REG_IMAGE_WIDTH ||
                                    csr_index == REG_IMAGE_HEIGHT);

   assign last_col = (CW1'(col_ff) + CW1'(1)) == CW1'(width_ff);
   assign last_row = (CFG_HEIGHT_W'(row_ff) + CFG_HEIGHT_W'(1)) == height_ff;

   // Clamp register values once, at write time.
   always_comb begin
      wv = int'(csr_wdata[CFG_WIDTH_W-1:0]);
      hv = int'(csr_wdata[CFG_HEIGHT_W-1:0]);
      if (wv == 0) begin
         wv = 1;
      end else if (wv > MAX_WIDTH) begin
         wv = MAX_WIDTH;
      end
      if (hv == 0) begin
         hv = 1;
      end else if (hv > MAX_HEIGHT) begin
         hv = MAX_HEIGHT;
      end
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid && csr_index == REG_IMAGE_WIDTH) begin
         width_in = EW'(wv);
      end
      if (csr_valid && csr_index == REG_IMAGE_HEIGHT) begin
         height_in = CFG_HEIGHT_W'(hv);
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cfg_hit) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   // Line store word: older row in the upper byte, newer row in the lower.
   assign line_word = byp_v_ff ? byp_data_ff : ram_rdata;
   assign top_px    = line_word[LW-1:PIX_W];
   assign mid_px    = line_word[PIX_W-1:0];
   assign wr_word   = {mid_px, s1_px_ff};

   lcs_ram #(
      .WIDTH (LW),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_v_ff),
      .wr_addr (s1_col_ff),
      .wr_data (wr_word),
      .rd_addr (col_ff),
      .rd_data (ram_rdata)
   );

   always_comb begin
      win_in = win_ff;
      if (s1_v_ff) begin
         for (int k = 0; k < 3; k++) begin
            win_in[k * 3 + 0] = win_ff[k * 3 + 1];
            win_in[k * 3 + 1] = win_ff[k * 3 + 2];
         end
         win_in[2] = top_px;
         win_in[5] = mid_px;
         win_in[8] = s1_px_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= EW'(RST_W);
         height_ff <= CFG_HEIGHT_W'(RESET_HEIGHT);
         col_ff    <= '0;
         row_ff    <= '0;
         s1_v_ff   <= 1'b0;
         byp_v_ff  <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         s1_v_ff   <= accept;
         // Read and write of one address in the same cycle: forward the write.
         byp_v_ff  <= s1_v_ff && (s1_col_ff == col_ff);
      end
   end

   always_ff @(posedge clock) begin
      byp_data_ff <= wr_word;
      win_ff      <= win_in;
      if (accept) begin
         s1_px_ff  <= req_pixel;
         s1_col_ff <= col_ff;
         s1_row_ff <= row_ff;
         s1_lc_ff  <= last_col;
         s1_lr_ff  <= last_row;
      end
   end

   assign push_valid         = s1_v_ff;
   assign push_item.win      = win_in;
   assign push_item.row      = s1_row_ff;
   assign push_item.last_col = s1_lc_ff;
   assign push_item.last_row = s1_lr_ff;
   assign push_col           = s1_col_ff;

endmodule

[hw/rtl/lcs_queue.sv]
// ----------------------------------------------------------------------------
// LBP pixel queue
// Short FIFO of pixel records between front and back end.
// ----------------------------------------------------------------------------
module lcs_queue #(
   parameter int MAX_WIDTH = lcs_pkg::DEF_MAX_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push_valid,
   input  lcs_pkg::lcs_item_type        push_item,
   input  logic [$clog2(MAX_WIDTH)-1:0] push_col,
   input  logic                         pop,
   output logic                         head_valid,
   output lcs_pkg::lcs_item_type        head_item,
   output logic [$clog2(MAX_WIDTH)-1:0] head_col,
   output logic [lcs_pkg::CNT_W-1:0]    count
);

   import lcs_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   lcs_item_type     item_ff [QUEUE_DEPTH];
   logic [COL_W-1:0] col_ff  [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push_valid ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push_valid) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         item_ff[wr_ptr_ff] <= push_item;
         col_ff[wr_ptr_ff]  <= push_col;
      end
   end

   assign head_valid = count_ff != '0;
   assign head_item  = item_ff[rd_ptr_ff];
   assign head_col   = col_ff[rd_ptr_ff];
   assign count      = count_ff;

endmodule

[hw/rtl/lcs_back.sv]
// ----------------------------------------------------------------------------
// LBP back end
// Walks the emission slots of the head record into the output register, one
// code per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module lcs_back #(
   parameter int MAX_WIDTH = lcs_pkg::DEF_MAX_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          head_valid,
   input  lcs_pkg::lcs_item_type         head_item,
   input  logic [$clog2(MAX_WIDTH)-1:0]  head_col,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lcs_pkg::CODE_W-1:0]    rsp_lbp_code,
   output logic [lcs_pkg::OUT_COL_W-1:0] rsp_out_col,
   output logic [lcs_pkg::ROW_W-1:0]     rsp_out_row,
   output logic                          rsp_last_of_frame
);

   import lcs_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);

   logic                  started_ff, started_in;
   logic [EMIT_N-1:0]     rem_ff, rem_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]     code_ff;
   logic [COL_W-1:0]      col_ff;
   logic [ROW_W-1:0]      row_ff;
   logic                  last_ff;

   logic [EMIT_N-1:0]     head_mask;
   logic [EMIT_N-1:0]     mask_cur;
   logic [EMIT_N-1:0]     sel;
   logic [EMIT_N-1:0]     rem_next;
   logic                  out_free;
   logic                  load;
   logic                  row_nz;
   logic                  col_nz;
   logic [1:0]            cr;
   logic [1:0]            cc;
   lcs_side_type          side;
   logic [CODE_W-1:0]     code;
   logic [COL_W-1:0]      emit_col;
   logic [ROW_W-1:0]      emit_row;

   assign row_nz = head_item.row != '0;
   assign col_nz = head_col != '0;

   always_comb begin
      head_mask[EMIT_PREV_ROW_LEFT] = row_nz && col_nz;
      head_mask[EMIT_PREV_ROW_END]  = row_nz && head_item.last_col;
      head_mask[EMIT_LAST_ROW_LEFT] = head_item.last_row && col_nz;
      head_mask[EMIT_LAST_ROW_END]  = head_item.last_row && head_item.last_col;
   end

   assign mask_cur = started_ff ? rem_ff : head_mask;
   assign sel      = mask_cur & (~mask_cur + EMIT_N'(1));
   assign rem_next = mask_cur & ~sel;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign load     = head_valid && (mask_cur != '0) && out_free;
   // Drop records with nothing to emit, retire the rest after their last slot.
   assign pop      = head_valid && ((mask_cur == '0) || (out_free && rem_next == '0));

   always_comb begin
      cr = (sel[EMIT_LAST_ROW_LEFT] || sel[EMIT_LAST_ROW_END]) ? 2'd2 : 2'd1;
      cc = (sel[EMIT_PREV_ROW_END] || sel[EMIT_LAST_ROW_END]) ? 2'd2 : 2'd1;
      side.up    = (cr == 2'd2) ? row_nz : (head_item.row >= ROW_W'(2));
      side.down  = cr == 2'd1;
      side.left  = (cc == 2'd2) ? col_nz : (head_col >= COL_W'(2));
      side.right = cc == 2'd1;
      code       = lcs_code(head_item.win, cr, cc, side);
      emit_col   = (cc == 2'd1) ? head_col - COL_W'(1) : head_col;
      emit_row   = (cr == 2'd1) ? head_item.row - ROW_W'(1) : head_item.row;
   end

   always_comb begin
      started_in = started_ff;
      rem_in     = rem_ff;
      if (pop) begin
         started_in = 1'b0;
      end else if (load) begin
         started_in = 1'b1;
         rem_in     = rem_next;
      end
      rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         started_ff   <= started_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         code_ff <= code;
         col_ff  <= emit_col;
         row_ff  <= emit_row;
         last_ff <= sel[EMIT_LAST_ROW_END];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_lbp_code      = code_ff;
   assign rsp_out_col       = OUT_COL_W'(col_ff);
   assign rsp_out_row       = row_ff;
   assign rsp_last_of_frame = last_ff;

endmodule

[hw/rtl/lbp_code_stream_unit.sv]
// ----------------------------------------------------------------------------
// LBP code stream unit
// 3x3 eight-neighbour local binary pattern over a raster pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one beat per pixel, and every pixel of the
// frame leaves as one code beat tagged with its column and row; a code comes
// out once all its in-image neighbours have arrived, so codes trail the input
// by about one row and the last row is flushed while its own pixels arrive.
// The back end delivers one code per cycle while the output is not stalled,
// so a pixel holds it for each code it releases: a pixel at a row end or on
// the last row may release two, and the frame's last pixel up to four. A
// four-record queue decouples the two ends, and the first code a pixel
// releases passes the front end's pixel register, then the queue, and then
// the output register before it reaches the port.
// Writing image_width or image_height restarts the frame; write them only
// while the block is idle. The line store needs no clearing pass after reset.
// ----------------------------------------------------------------------------
module lbp_code_stream_unit #(
   parameter int MAX_WIDTH = lcs_pkg::DEF_MAX_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [lcs_pkg::PIX_W-1:0]      req_pixel,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [lcs_pkg::CODE_W-1:0]     rsp_lbp_code,
   output logic [lcs_pkg::OUT_COL_W-1:0]  rsp_out_col,
   output logic [lcs_pkg::ROW_W-1:0]      rsp_out_row,
   output logic                           rsp_last_of_frame,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [lcs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lcs_pkg::CSR_DATA_W-1:0] csr_wdata
);

   import lcs_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);

   // Front to queue: one record per accepted pixel.
   logic             push_valid;
   lcs_item_type     push_item;
   logic [COL_W-1:0] push_col;

   // Queue to back end.
   logic             head_valid;
   lcs_item_type     head_item;
   logic [COL_W-1:0] head_col;
   logic             pop;
   logic [CNT_W-1:0] q_count;

   // Front end: hold the frame position, advance the window, fill the queue.
   lcs_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_pixel  (req_pixel),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_count    (q_count),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_col   (push_col)
   );

   lcs_queue #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_col   (push_col),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_col   (head_col),
      .count      (q_count)
   );

   // Back end: expand each record into zero to four code beats.
   lcs_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_item         (head_item),
      .head_col          (head_col),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_lbp_code      (rsp_lbp_code),
      .rsp_out_col       (rsp_out_col),
      .rsp_out_row       (rsp_out_row),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

endmodule

[hw/rtl/lcs_checker.sv]
// ----------------------------------------------------------------------------
// LBP port checker
// Port-level assertions for the code stream unit, bound to the top level.
// ----------------------------------------------------------------------------
module lcs_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [lcs_pkg::CODE_W-1:0]     rsp_lbp_code,
   input logic [lcs_pkg::OUT_COL_W-1:0]  rsp_out_col,
   input logic [lcs_pkg::ROW_W-1:0]      rsp_out_row,
   input logic                           rsp_last_of_frame
);

   // A stalled code beat holds until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_lbp_code) &&
         $stable(rsp_out_col) && $stable(rsp_out_row) && $stable(rsp_last_of_frame))
      else $error("code beat changed while stalled");

   // No code appears without a pixel behind it after reset.
   a_no_spurious: assert property (@(posedge clock)
      reset ##1 !(req_valid && req_ready) |=> !rsp_valid)
      else $error("code beat without an accepted pixel");

   // The frame's last pixel has no right or lower neighbours.
   a_last_edges: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_frame |-> rsp_lbp_code[6:2] == 5'd0)
      else $error("right or lower bits set on last code of frame");

   // Top row: no upper neighbours.
   a_top_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_row == '0 |->
         !rsp_lbp_code[7] && !rsp_lbp_code[6] && !rsp_lbp_code[0])
      else $error("upper bits set on top row code");

   // Left column: no left neighbours.
   a_left_col: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_col == '0 |-> rsp_lbp_code[2:0] == 3'd0)
      else $error("left bits set on left column code");

endmodule

bind lbp_code_stream_unit lcs_checker u_checker (.*);

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// LBP code stream unit testbench
// Streams grey pixels through the unit and checks every code beat against a
// local prediction of the 3x3 pattern, its column, row and frame-end flag.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lcs_pkg::*;

   // Register indexes past the end of the register list: writes are dropped.
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_B = 2'd3;

   localparam int MAX_COLS     = DEF_MAX_WIDTH;
   localparam int MAX_ROWS     = MAX_HEIGHT;
   localparam int QUIET_CYCLES = 12;

   // Neighbour walk: up, up-right, right, down-right, down, down-left, left,
   // up-left; the first one lands in code bit 7.
   localparam int ROW_STEP [8] = '{-1, -1, 0, 1, 1, 1, 0, -1};
   localparam int COL_STEP [8] = '{ 0,  1, 1, 1, 0, -1, -1, -1};

   typedef struct packed {
      logic [CODE_W-1:0]    code;
      logic [OUT_COL_W-1:0] col;
      logic [ROW_W-1:0]     row;
      logic                 last;
   } lbp_beat_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_valid  = 1'b0;
   logic                  req_ready;
   logic [PIX_W-1:0]      req_pixel  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready  = 1'b0;
   logic [CODE_W-1:0]     rsp_lbp_code;
   logic [OUT_COL_W-1:0]  rsp_out_col;
   logic [ROW_W-1:0]      rsp_out_row;
   logic                  rsp_last_of_frame;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // Idle odds in percent, set per phase.
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int error_count    = 0;

   // Predicted state of the unit: configuration, both line stores, the 3x3
   // window (index row*3+col, column 2 newest) and the next raster position.
   logic [CFG_WIDTH_W-1:0]  cfg_width;
   logic [CFG_HEIGHT_W-1:0] cfg_height;
   logic [PIX_W-1:0]        older_mem [MAX_COLS];
   logic [PIX_W-1:0]        newer_mem [MAX_COLS];
   logic [PIX_W-1:0]        pixel_window [9];
   int unsigned             pos_col;
   int unsigned             pos_row;

   // Code beats still owed by the unit, oldest first.
   lbp_beat_type pending_codes [$];

   lbp_code_stream_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_pixel         (req_pixel),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_lbp_code      (rsp_lbp_code),
      .rsp_out_col       (rsp_out_col),
      .rsp_out_row       (rsp_out_row),
      .rsp_last_of_frame (rsp_last_of_frame),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case a handshake never completes.
   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   // Receiver: decide the stall for the next cycle on each falling edge.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Pattern of window cell (cr,cc); the flags say which sides lie inside the
   // image. Neighbours off the window or outside the image leave their bit 0.
   function automatic logic [CODE_W-1:0] pattern_at(int cr, int cc, bit has_up,
                                                    bit has_down, bit has_left,
                                                    bit has_right);
      logic [CODE_W-1:0] code;
      int                nr;
      int                nc;
      bit                inside_img;
      code = '0;
      for (int k = 0; k < 8; k++) begin
         nr = cr + ROW_STEP[k];
         nc = cc + COL_STEP[k];
         inside_img = !((ROW_STEP[k] < 0 && !has_up) || (ROW_STEP[k] > 0 && !has_down) ||
                        (COL_STEP[k] < 0 && !has_left) || (COL_STEP[k] > 0 && !has_right));
         if (inside_img && nr >= 0 && nr <= 2 && nc >= 0 && nc <= 2 &&
             pixel_window[cr * 3 + cc] <= pixel_window[nr * 3 + nc]) begin
            code[7 - k] = 1'b1;
         end
      end
      return code;
   endfunction

   task automatic queue_code(logic [CODE_W-1:0] code, int unsigned col, int unsigned row,
                             bit last);
      lbp_beat_type beat;
      beat.code = code;
      beat.col  = col[OUT_COL_W-1:0];
      beat.row  = row[ROW_W-1:0];
      beat.last = last;
      pending_codes.push_back(beat);
   endtask

   // Advance the predicted unit by one accepted pixel and queue the codes it
   // releases, in the order the unit sends them.
   task automatic predict_codes(logic [PIX_W-1:0] pix);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      bit          end_col;
      bit          end_row;
      // Zero sizes count as one, oversized ones clip to the store limits.
      w = (cfg_width == 0) ? 1 : (cfg_width > MAX_COLS) ? MAX_COLS : cfg_width;
      h = (cfg_height == 0) ? 1 : (cfg_height > MAX_ROWS) ? MAX_ROWS : cfg_height;
      if (pos_col >= w || pos_row >= h) begin
         pos_col = 0;
         pos_row = 0;
      end
      c = pos_col;
      r = pos_row;

      // Shift the window left and load the new column from the line stores.
      for (int k = 0; k < 3; k++) begin
         pixel_window[k * 3]     = pixel_window[k * 3 + 1];
         pixel_window[k * 3 + 1] = pixel_window[k * 3 + 2];
      end
      pixel_window[2] = older_mem[c];
      pixel_window[5] = newer_mem[c];
      pixel_window[8] = pix;
      older_mem[c]    = newer_mem[c];
      newer_mem[c]    = pix;

      end_col = (c + 1 == w);
      end_row = (r + 1 == h);

      // Row above: its pixel one column back is now complete, and at row end
      // its last pixel too.
      if (r > 0) begin
         if (c > 0) queue_code(pattern_at(1, 1, r >= 2, 1, c >= 2, 1), c - 1, r - 1, 0);
         if (end_col) queue_code(pattern_at(1, 2, r >= 2, 1, c >= 1, 0), c, r - 1, 0);
      end
      // Bottom row has no row below, so flush it as it arrives.
      if (end_row) begin
         if (c > 0) queue_code(pattern_at(2, 1, r >= 1, 0, c >= 2, 1), c - 1, r, 0);
         if (end_col) queue_code(pattern_at(2, 2, r >= 1, 0, c >= 1, 0), c, r, 1);
      end

      if (end_col) begin
         pos_col = 0;
         pos_row = end_row ? 0 : r + 1;
      end else begin
         pos_col = c + 1;
      end
   endtask

   // Send one pixel beat, idling first at the sender's odds, and predict it
   // once it is taken.
   task automatic send_pixel(logic [PIX_W-1:0] pix);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= pix;
      do @(posedge clock); while (!req_ready);
      predict_codes(pix);
   endtask

   // Random pixels; clustered ones sit within two grey levels of each
   // other so that ties and near ties are frequent.
   task automatic send_pixels(int unsigned count, bit clustered);
      logic [PIX_W-1:0] base;
      logic [PIX_W-1:0] pix;
      base = PIX_W'($urandom_range(253));
      repeat (count) begin
         pix = clustered ? PIX_W'(base + $urandom_range(2)) : PIX_W'($urandom);
         send_pixel(pix);
      end
   endtask

   // Drop valid, wait for every owed code, then give the unit time to finish
   // pixels that release no code.
   task automatic wait_quiet();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_codes.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // Write one register; a write to a real register restarts the frame.
   task automatic csr_write(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      case (index)
         REG_IMAGE_WIDTH: begin
            cfg_width = data[CFG_WIDTH_W-1:0];
            pos_col   = 0;
            pos_row   = 0;
         end
         REG_IMAGE_HEIGHT: begin
            cfg_height = data[CFG_HEIGHT_W-1:0];
            pos_col    = 0;
            pos_row    = 0;
         end
         default: ;
      endcase
   endtask

   task automatic set_frame(int unsigned w, int unsigned h);
      wait_quiet();
      csr_write(REG_IMAGE_WIDTH, CSR_DATA_W'(w));
      csr_write(REG_IMAGE_HEIGHT, CSR_DATA_W'(h));
   endtask

   task automatic set_idling(int idle_pct, int stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
   endtask

   // Reset sizes are 128x128: a few pixels of row 0 release nothing.
   task automatic test_reset_defaults();
      set_idling(0, 0);
      send_pixel(8'd17);
      send_pixel(8'd200);
      send_pixel(8'd17);
   endtask

   // Single pixels, zero sizes, ties and strict orders in a 3x3 frame.
   task automatic test_small_frames();
      set_idling(10, 10);
      set_frame(1, 1);
      send_pixel(8'd0);
      send_pixel(8'd255);
      // Zero width and height behave as one pixel.
      set_frame(0, 0);
      send_pixel(8'd128);
      set_frame(3, 3);
      send_pixel(8'd129);
      send_pixel(8'd128);
      send_pixel(8'd127);
      send_pixel(8'd127);
      send_pixel(8'd128);
      send_pixel(8'd129);
      send_pixel(8'd128);
      send_pixel(8'd255);
      send_pixel(8'd0);
      // Flat frame: every in-image neighbour ties with its centre.
      repeat (9) send_pixel(8'd255);
   endtask

   // Spare indexes leave a frame running; a real write restarts it.
   task automatic test_register_effects();
      set_idling(60, 0);
      set_frame(4, 4);
      send_pixels(6, 0);
      wait_quiet();
      csr_write(REG_SPARE_A, 13'h1555);
      csr_write(REG_SPARE_B, 13'h0AAA);
      send_pixels(10, 1);
      set_frame(5, 3);
      send_pixels(7, 0);
      wait_quiet();
      csr_write(REG_IMAGE_WIDTH, 13'd5);
      send_pixels(15, 1);
   endtask

   // Oversized width and height writes clip to the store limits; partial
   // frames at those sizes and at the largest exact sizes.
   task automatic test_size_limits();
      set_idling(0, 60);
      set_frame('1, 1);
      send_pixels(64, 0);
      set_idling(0, 0);
      set_frame(MAX_COLS, MAX_ROWS);
      send_pixels(8, 0);
      set_frame(1, '1);
      send_pixels(40, 1);
   endtask

   // Random frame shapes: mostly whole frames, some back to back without a
   // write, some cut short by the next write.
   task automatic test_random_frames(int idle_pct, int stall_pct, int unsigned budget);
      int unsigned           sent;
      int unsigned           w;
      int unsigned           h;
      int unsigned           count;
      logic [CSR_DATA_W-1:0] wdata;
      set_idling(idle_pct, stall_pct);
      sent = 0;
      while (sent < budget) begin
         w = $urandom_range(1, 16);
         h = $urandom_range(1, 8);
         if ($urandom_range(9) == 0) begin
            w = $urandom_range(17, 64);
            h = $urandom_range(1, 3);
         end
         wait_quiet();
         // Bits above the width register are ignored; fill them at random.
         wdata = CSR_DATA_W'($urandom);
         wdata[CFG_WIDTH_W-1:0] = CFG_WIDTH_W'(w);
         csr_write(REG_IMAGE_WIDTH, wdata);
         csr_write(REG_IMAGE_HEIGHT, CSR_DATA_W'(h));
         if ($urandom_range(7) == 0) begin
            csr_write($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B,
                      CSR_DATA_W'($urandom));
         end
         count = w * h;
         case ($urandom_range(9))
            0, 1: count = $urandom_range(1, w * h);
            2, 3: count = 2 * w * h;
            default: ;
         endcase
         send_pixels(count, $urandom_range(1));
         sent += count;
      end
   endtask

   // Compare each taken code beat with the oldest prediction.
   always @(posedge clock) begin : check_codes
      lbp_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_codes.size() == 0) begin
            $error("code beat with none pending: col %0d row %0d", rsp_out_col, rsp_out_row);
            error_count++;
         end else begin
            want = pending_codes.pop_front();
            if (rsp_lbp_code !== want.code) begin
               $error("lbp_code: expected %0d, actual %0d", want.code, rsp_lbp_code);
               error_count++;
            end
            if (rsp_out_col !== want.col) begin
               $error("out_col: expected %0d, actual %0d", want.col, rsp_out_col);
               error_count++;
            end
            if (rsp_out_row !== want.row) begin
               $error("out_row: expected %0d, actual %0d", want.row, rsp_out_row);
               error_count++;
            end
            if (rsp_last_of_frame !== want.last) begin
               $error("last_of_frame: expected %0d, actual %0d", want.last,
                      rsp_last_of_frame);
               error_count++;
            end
         end
      end
   end

   initial begin
      // Predicted state after reset.
      cfg_width  = CFG_WIDTH_W'(RESET_WIDTH);
      cfg_height = CFG_HEIGHT_W'(RESET_HEIGHT);
      pos_col    = 0;
      pos_row    = 0;
      for (int k = 0; k < MAX_COLS; k++) begin
         older_mem[k] = '0;
         newer_mem[k] = '0;
      end
      for (int k = 0; k < 9; k++) pixel_window[k] = '0;

      // Hold reset, then release it on a falling edge.
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_small_frames();
      test_register_effects();
      test_size_limits();
      test_random_frames(0, 0, 80);
      test_random_frames(60, 0, 80);
      test_random_frames(0, 60, 80);
      test_random_frames(10, 10, 80);

      // Drain every owed code and let any late stray beat show up.
      wait_quiet();
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
